// File: rtl/vram_aperture_window_translator_defines.svh
// Assertion macros for the window translator RTL.
`ifndef VRAM_APERTURE_WINDOW_TRANSLATOR_DEFINES_SVH
`define VRAM_APERTURE_WINDOW_TRANSLATOR_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define VAWT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vawt: same-cycle check failed");

// Checks that a condition implies a consequence in the next cycle.
`define VAWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vawt: next-cycle check failed");

`endif

// File: rtl/vawt_pkg.sv
// Types and constants of the memory-aperture window translator.
package vawt_pkg;

   // Operation codes of an incoming access.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Target space codes of a downstream access.
   localparam logic SPACE_REGISTER = 1'b0;
   localparam logic SPACE_APERTURE = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 42;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GUEST_MEMORY_SIZE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GUEST_ADDRESS_SHIFT = 2'd1;

   // Field widths.
   localparam int unsigned SIZE_WIDTH  = 41;
   localparam int unsigned SHIFT_WIDTH = 42;
   localparam int unsigned BASE_WIDTH  = 40;
   localparam int unsigned PHYS_WIDTH  = 43;

   // Fixed offsets and data values.
   localparam logic [31:0] CTRL_OFFSET    = 32'hFFFF_0000;
   localparam logic [31:0] WIN_REG_OFFSET = 32'h0000_1700;
   localparam logic [31:0] FAULT_DATA     = 32'hFFFF_FFFF;
   localparam logic [31:0] PAGE_ENABLE    = 32'h0000_0001;

   // One downstream access.
   typedef struct packed {
      logic        target_space;
      logic [31:0] target_offset;
      logic [31:0] target_data;
      logic        is_read;
      logic        fault;
      logic        last;
   } rsp_type;

   // Everything one access turns into.
   typedef struct packed {
      logic [1:0]            count;
      rsp_type               rsp0;
      rsp_type               rsp1;
      logic                  win_update;
      logic [BASE_WIDTH-1:0] win_base;
   } xlate_type;

endpackage

// File: rtl/vawt_xlate.sv
// Translation of one guest aperture access into downstream accesses.
module vawt_xlate #(
   parameter int unsigned WINDOW_BYTES = 268435456
) (
   input  logic                               operation,
   input  logic [31:0]                        access_offset,
   input  logic [31:0]                        write_data,
   input  logic [vawt_pkg::BASE_WIDTH-1:0]    aperture_base,
   input  logic [vawt_pkg::SIZE_WIDTH-1:0]    guest_memory_size,
   input  logic [vawt_pkg::SHIFT_WIDTH-1:0]   guest_address_shift,
   output vawt_pkg::xlate_type                xlate
);

   logic                              is_read;
   logic                              is_ctrl;
   logic [51:0]                       proposed_base;
   logic                              base_ok;
   logic                              big_memory;
   logic                              win_fault;
   logic [vawt_pkg::SIZE_WIDTH-1:0]   addr;
   logic                              bad;
   logic [vawt_pkg::PHYS_WIDTH-1:0]   phys;
   logic [31:0]                       down_data;
   logic                              split;

   // Window control decode and new base check.
   assign is_read    = (operation == vawt_pkg::OP_READ);
   assign is_ctrl    = !is_read && (access_offset == vawt_pkg::CTRL_OFFSET);
   assign proposed_base = {write_data, 20'b0};
   assign base_ok    = proposed_base < 52'(guest_memory_size);

   // Windowed addressing applies only when memory is 4 GiB or more.
   assign big_memory = (guest_memory_size[vawt_pkg::SIZE_WIDTH-1:32] != '0);
   assign win_fault  = big_memory && ({1'b0, access_offset} >= 33'(WINDOW_BYTES));
   assign addr       = big_memory
                     ? vawt_pkg::SIZE_WIDTH'(access_offset)
                       + vawt_pkg::SIZE_WIDTH'(aperture_base)
                     : vawt_pkg::SIZE_WIDTH'(access_offset);
   assign bad        = win_fault || (addr >= guest_memory_size);

   // Physical address and split decision.
   assign phys       = vawt_pkg::PHYS_WIDTH'(addr)
                     + vawt_pkg::PHYS_WIDTH'(guest_address_shift);
   assign split      = (phys[vawt_pkg::PHYS_WIDTH-1:32] != '0);
   assign down_data  = is_read ? 32'd0 : write_data;

   // Assemble the result pair.
   always_comb begin
      xlate            = '0;
      xlate.win_base   = proposed_base[vawt_pkg::BASE_WIDTH-1:0];
      if (is_ctrl) begin
         xlate.win_update = base_ok;
      end else if (bad) begin
         if (is_read) begin
            xlate.count              = 2'd1;
            xlate.rsp0.target_space  = vawt_pkg::SPACE_APERTURE;
            xlate.rsp0.target_offset = 32'd0;
            xlate.rsp0.target_data   = vawt_pkg::FAULT_DATA;
            xlate.rsp0.is_read       = 1'b1;
            xlate.rsp0.fault         = 1'b1;
            xlate.rsp0.last          = 1'b1;
         end
      end else if (split) begin
         xlate.count              = 2'd2;
         xlate.rsp0.target_space  = vawt_pkg::SPACE_REGISTER;
         xlate.rsp0.target_offset = vawt_pkg::WIN_REG_OFFSET;
         xlate.rsp0.target_data   = 32'(phys[vawt_pkg::PHYS_WIDTH-1:16])
                                  | vawt_pkg::PAGE_ENABLE;
         xlate.rsp1.target_space  = vawt_pkg::SPACE_APERTURE;
         xlate.rsp1.target_offset = {16'd0, phys[15:0]};
         xlate.rsp1.target_data   = down_data;
         xlate.rsp1.is_read       = is_read;
         xlate.rsp1.last          = 1'b1;
      end else begin
         xlate.count              = 2'd1;
         xlate.rsp0.target_space  = vawt_pkg::SPACE_APERTURE;
         xlate.rsp0.target_offset = phys[31:0];
         xlate.rsp0.target_data   = down_data;
         xlate.rsp0.is_read       = is_read;
         xlate.rsp0.last          = 1'b1;
      end
   end

endmodule

// File: rtl/vawt_rsp_stage.sv
// Result register that holds up to two downstream accesses and sends them in order.
`include "vram_aperture_window_translator_defines.svh"

module vawt_rsp_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  logic [1:0]           load_count,
   input  vawt_pkg::rsp_type    load_rsp0,
   input  vawt_pkg::rsp_type    load_rsp1,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vawt_pkg::rsp_type    rsp
);

   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   vawt_pkg::rsp_type   slot0_ff;
   vawt_pkg::rsp_type   slot0_in;
   vawt_pkg::rsp_type   slot1_ff;
   vawt_pkg::rsp_type   slot1_in;
   logic                pop;
   logic                load;

   // A new pair may enter once the stage is empty or empties this cycle.
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp       = slot0_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign can_load  = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);
   assign load      = load_valid && can_load;

   // Next contents of the slots.
   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         count_in = load_count;
         slot0_in = load_rsp0;
         slot1_in = load_rsp1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // The stage never holds more than one pair.
   `VAWT_ASSERT_SAME(a_count_max, clock, reset, 1'b1, count_ff != 2'd3)
   // A result that is not last is always a window register write.
   `VAWT_ASSERT_SAME(a_first_is_reg, clock, reset, rsp_valid && !rsp.last,
      rsp.target_space == vawt_pkg::SPACE_REGISTER && !rsp.is_read && !rsp.fault)
   // The in-page access follows its window register write directly.
   `VAWT_ASSERT_NEXT(a_second_follows, clock, reset, pop && !rsp.last,
      rsp_valid && rsp.last && rsp.target_space == vawt_pkg::SPACE_APERTURE)
   // A fault result carries the fault data and closes its transaction.
   `VAWT_ASSERT_SAME(a_fault_form, clock, reset, rsp_valid && rsp.fault,
      rsp.last && rsp.is_read && rsp.target_data == vawt_pkg::FAULT_DATA)

endmodule

// File: rtl/vram_aperture_window_translator.sv
// Top level of the memory-aperture window translator.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    operation, access_offset, write_data
//   rsp      out        rsp_valid/stall    space, offset, data, is_read, fault, last
//   csr      in         csr_valid/ready    csr_index, csr_data
//
// A transaction is registered on acceptance and translated in the next cycle into
// zero, one or two results, which land in the result register.
// Sustained rate is one transaction per cycle while rsp does not stall; a
// transaction that needs a window register write ahead of its access holds the
// result register until both its results have left.
// Reset clears the window base, both configuration registers and all valid state.
// A stall on rsp holds the result register and, once it is full, stalls req.
module vram_aperture_window_translator #(
   parameter int unsigned WINDOW_BYTES = 268435456
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_operation,
   input  logic [31:0]                            req_access_offset,
   input  logic [31:0]                            req_write_data,
   // Result channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_target_space,
   output logic [31:0]                            rsp_target_offset,
   output logic [31:0]                            rsp_target_data,
   output logic                                   rsp_is_read,
   output logic                                   rsp_fault,
   output logic                                   rsp_last,
   // Configuration channel.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [vawt_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [vawt_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   logic                               req_vld_ff;
   logic                               req_vld_in;
   logic                               op_ff;
   logic [31:0]                        offset_ff;
   logic [31:0]                        data_ff;
   logic [vawt_pkg::BASE_WIDTH-1:0]    aperture_base_ff;
   logic [vawt_pkg::BASE_WIDTH-1:0]    aperture_base_in;
   logic [vawt_pkg::SIZE_WIDTH-1:0]    mem_size_ff;
   logic [vawt_pkg::SIZE_WIDTH-1:0]    mem_size_in;
   logic [vawt_pkg::SHIFT_WIDTH-1:0]   addr_shift_ff;
   logic [vawt_pkg::SHIFT_WIDTH-1:0]   addr_shift_in;
   logic                               accept;
   logic                               advance;
   logic                               can_load;
   vawt_pkg::xlate_type                xlate;
   vawt_pkg::rsp_type                  rsp;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      mem_size_in   = mem_size_ff;
      addr_shift_in = addr_shift_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            vawt_pkg::CSR_GUEST_MEMORY_SIZE: begin
               mem_size_in = csr_data[vawt_pkg::SIZE_WIDTH-1:0];
            end
            vawt_pkg::CSR_GUEST_ADDRESS_SHIFT: begin
               addr_shift_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Input register handshake: the held transaction leaves when its results fit.
   assign advance    = req_vld_ff && ((xlate.count == 2'd0) || can_load);
   assign req_stall  = req_vld_ff && !advance;
   assign accept     = req_valid && !req_stall;
   assign req_vld_in = accept || (req_vld_ff && !advance);

   // Window base moves when a control write leaves the input register.
   assign aperture_base_in = (advance && xlate.win_update) ? xlate.win_base
                                                          : aperture_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff       <= 1'b0;
         aperture_base_ff <= '0;
         mem_size_ff      <= '0;
         addr_shift_ff    <= '0;
      end else begin
         req_vld_ff       <= req_vld_in;
         aperture_base_ff <= aperture_base_in;
         mem_size_ff      <= mem_size_in;
         addr_shift_ff    <= addr_shift_in;
      end
      if (accept) begin
         op_ff     <= req_operation;
         offset_ff <= req_access_offset;
         data_ff   <= req_write_data;
      end
   end

   // Translation of the held transaction.
   vawt_xlate #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_xlate (
      .operation           (op_ff),
      .access_offset       (offset_ff),
      .write_data          (data_ff),
      .aperture_base       (aperture_base_ff),
      .guest_memory_size   (mem_size_ff),
      .guest_address_shift (addr_shift_ff),
      .xlate               (xlate)
   );

   // Result register.
   vawt_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_vld_ff && (xlate.count != 2'd0)),
      .load_count (xlate.count),
      .load_rsp0  (xlate.rsp0),
      .load_rsp1  (xlate.rsp1),
      .can_load   (can_load),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_target_space  = rsp.target_space;
   assign rsp_target_offset = rsp.target_offset;
   assign rsp_target_data   = rsp.target_data;
   assign rsp_is_read       = rsp.is_read;
   assign rsp_fault         = rsp.fault;
   assign rsp_last          = rsp.last;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the memory-aperture window translator.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned WINDOW_SPAN = 268435456;

   // Kinds of rows in the directed table.
   typedef enum logic {ROW_CSR, ROW_ACCESS} row_kind_type;

   // One directed row: a register write or an access, with an optional typed-in result.
   // A typed count of -1 leaves the result to the translation model.
   typedef struct {
      row_kind_type          kind;
      logic [1:0]            csr_idx;
      logic [41:0]           csr_value;
      logic                  op;
      logic [31:0]           ofs;
      logic [31:0]           data;
      int                    typed_count;
      vawt_pkg::rsp_type     typed_rsp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = vawt_pkg::OP_WRITE;
   logic [31:0] req_access_offset = '0;
   logic [31:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_target_space;
   logic [31:0] rsp_target_offset;
   logic [31:0] rsp_target_data;
   logic        rsp_is_read;
   logic        rsp_fault;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [vawt_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [vawt_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // Model copy of the configuration and the window base.
   logic [40:0] mem_size_cfg = '0;
   logic [41:0] addr_shift_cfg = '0;
   logic [39:0] aperture_base_model = '0;

   // Downstream accesses that are still to come, oldest first.
   vawt_pkg::rsp_type expected_accesses[$];
   int                mismatch_count = 0;
   int                sender_max_gap = 12;
   int                receiver_max_stall = 12;
   stim_row_type      directed_rows[$];

   vram_aperture_window_translator #(
      .WINDOW_BYTES(WINDOW_SPAN)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_access_offset(req_access_offset),
      .req_write_data(req_write_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_target_space(rsp_target_space),
      .rsp_target_offset(rsp_target_offset),
      .rsp_target_data(rsp_target_data),
      .rsp_is_read(rsp_is_read),
      .rsp_fault(rsp_fault),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // Generous ceiling on the whole run.
   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic vawt_pkg::rsp_type make_rsp(logic space, logic [31:0] ofs,
                                                  logic [31:0] data, logic rd, logic flt,
                                                  logic lst);
      vawt_pkg::rsp_type r;
      r.target_space  = space;
      r.target_offset = ofs;
      r.target_data   = data;
      r.is_read       = rd;
      r.fault         = flt;
      r.last          = lst;
      return r;
   endfunction

   // Translates one guest access into downstream accesses and returns how many there are.
   // A window control write only moves the window base.
   function automatic int translate_access(input logic op, input logic [31:0] ofs,
                                           input logic [31:0] data,
                                           output vawt_pkg::rsp_type first,
                                           output vawt_pkg::rsp_type second);
      logic [63:0] proposed_base;
      logic [63:0] guest_addr;
      logic [63:0] phys;
      logic [31:0] down_data;
      logic        bad;
      first  = '0;
      second = '0;
      if (op == vawt_pkg::OP_WRITE && ofs == vawt_pkg::CTRL_OFFSET) begin
         proposed_base = {32'b0, data} << 20;
         if (proposed_base < {23'b0, mem_size_cfg}) begin
            aperture_base_model = proposed_base[39:0];
         end
         return 0;
      end

      // From 4 GiB of memory up only the window is reachable, and it slides over memory.
      guest_addr = {32'b0, ofs};
      bad = 1'b0;
      if (mem_size_cfg > 41'hFFFF_FFFF) begin
         if (guest_addr >= WINDOW_SPAN) begin
            bad = 1'b1;
         end else begin
            guest_addr = guest_addr + {24'b0, aperture_base_model};
         end
      end
      if (!bad && guest_addr >= {23'b0, mem_size_cfg}) begin
         bad = 1'b1;
      end
      if (bad) begin
         if (op == vawt_pkg::OP_WRITE) begin
            return 0;
         end
         first = make_rsp(vawt_pkg::SPACE_APERTURE, 32'h0, vawt_pkg::FAULT_DATA,
                          1'b1, 1'b1, 1'b1);
         return 1;
      end

      // A physical address past 32 bits needs the page set in the window register first.
      phys = guest_addr + {22'b0, addr_shift_cfg};
      down_data = (op == vawt_pkg::OP_READ) ? 32'h0 : data;
      if (phys > 64'hFFFF_FFFF) begin
         first  = make_rsp(vawt_pkg::SPACE_REGISTER, vawt_pkg::WIN_REG_OFFSET,
                           phys[47:16] | vawt_pkg::PAGE_ENABLE, 1'b0, 1'b0, 1'b0);
         second = make_rsp(vawt_pkg::SPACE_APERTURE, {16'h0, phys[15:0]}, down_data,
                           op == vawt_pkg::OP_READ, 1'b0, 1'b1);
         return 2;
      end
      first = make_rsp(vawt_pkg::SPACE_APERTURE, phys[31:0], down_data,
                       op == vawt_pkg::OP_READ, 1'b0, 1'b1);
      return 1;
   endfunction

   function automatic stim_row_type csr_row(logic [1:0] idx, logic [41:0] value);
      stim_row_type r;
      r.kind        = ROW_CSR;
      r.csr_idx     = idx;
      r.csr_value   = value;
      r.op          = vawt_pkg::OP_WRITE;
      r.ofs         = '0;
      r.data        = '0;
      r.typed_count = -1;
      r.typed_rsp   = '0;
      return r;
   endfunction

   function automatic stim_row_type access_row(logic op, logic [31:0] ofs, logic [31:0] data,
                                               int typed_count,
                                               vawt_pkg::rsp_type typed_rsp);
      stim_row_type r;
      r.kind        = ROW_ACCESS;
      r.csr_idx     = '0;
      r.csr_value   = '0;
      r.op          = op;
      r.ofs         = ofs;
      r.data        = data;
      r.typed_count = typed_count;
      r.typed_rsp   = typed_rsp;
      return r;
   endfunction

   // Offers one access after a random gap and records what it should turn into.
   task automatic drive_access(input logic op, input logic [31:0] ofs, input logic [31:0] data,
                               input int typed_count, input vawt_pkg::rsp_type typed_rsp);
      int                gap;
      int                n;
      vawt_pkg::rsp_type r0;
      vawt_pkg::rsp_type r1;
      gap = $urandom_range(0, sender_max_gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_operation     = op;
      req_access_offset = ofs;
      req_write_data    = data;
      do @(posedge clock); while (req_stall !== 1'b0);
      n = translate_access(op, ofs, data, r0, r1);
      if (typed_count >= 0) begin
         if (typed_count > 0) expected_accesses.push_back(typed_rsp);
      end else begin
         if (n >= 1) expected_accesses.push_back(r0);
         if (n == 2) expected_accesses.push_back(r1);
      end
   endtask

   // Waits until every expected result has come and the pipeline has drained.
   task automatic settle_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_accesses.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes one configuration register while the block is idle.
   task automatic write_register(input logic [1:0] idx, input logic [41:0] value);
      settle_block();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == vawt_pkg::CSR_GUEST_MEMORY_SIZE) begin
         mem_size_cfg = value[40:0];
      end else begin
         addr_shift_cfg = value;
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Draws a random access, mostly in range, with window moves and some noise.
   task automatic draw_access(output logic op, output logic [31:0] ofs,
                              output logic [31:0] data);
      int unsigned pick;
      logic [40:0] top;
      pick = $urandom_range(0, 99);
      data = $urandom();
      op   = ($urandom_range(0, 1) == 1) ? vawt_pkg::OP_READ : vawt_pkg::OP_WRITE;
      top  = (mem_size_cfg == 0) ? '0 : mem_size_cfg - 41'd1;
      if (pick < 12) begin
         op  = vawt_pkg::OP_WRITE;
         ofs = vawt_pkg::CTRL_OFFSET;
         if (pick < 9) data = $urandom_range(0, {11'b0, top[40:20]});
      end else if (pick < 16) begin
         op  = vawt_pkg::OP_READ;
         ofs = vawt_pkg::CTRL_OFFSET;
      end else if (pick < 26 || mem_size_cfg == 0) begin
         ofs = $urandom();
      end else if (mem_size_cfg > 41'hFFFF_FFFF) begin
         ofs = $urandom_range(0, WINDOW_SPAN - 1);
      end else begin
         ofs = $urandom_range(0, top[31:0]);
      end
   endtask

   // Result side: random stalls, with one long hold-off to back up the input.
   initial begin : result_sink
      int hold;
      int taken;
      bit long_hold_done;
      taken = 0;
      long_hold_done = 0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (taken == 200 && !long_hold_done) begin
            hold = 400;
            long_hold_done = 1;
         end else begin
            hold = $urandom_range(0, receiver_max_stall);
         end
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall = 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken++;
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin : result_check
      vawt_pkg::rsp_type got;
      vawt_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = make_rsp(rsp_target_space, rsp_target_offset, rsp_target_data,
                        rsp_is_read, rsp_fault, rsp_last);
         if (expected_accesses.size() == 0) begin
            $error("unexpected result: offset %h data %h", got.target_offset, got.target_data);
            mismatch_count++;
         end else begin
            want = expected_accesses.pop_front();
            if (got.target_space !== want.target_space) begin
               $error("target_space: expected %0h, got %0h", want.target_space,
                      got.target_space);
               mismatch_count++;
            end
            if (got.target_offset !== want.target_offset) begin
               $error("target_offset: expected %h, got %h", want.target_offset,
                      got.target_offset);
               mismatch_count++;
            end
            if (got.target_data !== want.target_data) begin
               $error("target_data: expected %h, got %h", want.target_data, got.target_data);
               mismatch_count++;
            end
            if (got.is_read !== want.is_read) begin
               $error("is_read: expected %0h, got %0h", want.is_read, got.is_read);
               mismatch_count++;
            end
            if (got.fault !== want.fault) begin
               $error("fault: expected %0h, got %0h", want.fault, got.fault);
               mismatch_count++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0h, got %0h", want.last, got.last);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus: directed table, then random phases over several configurations.
   initial begin : stimulus
      stim_row_type      row;
      vawt_pkg::rsp_type fault_rsp;
      vawt_pkg::rsp_type none;
      logic [63:0]       wide;
      logic [41:0]       size_value;
      logic [41:0]       shift_value;
      logic              op;
      logic [31:0]       ofs;
      logic [31:0]       data;
      int                wait_cycles;

      fault_rsp = make_rsp(vawt_pkg::SPACE_APERTURE, 32'h0, vawt_pkg::FAULT_DATA,
                           1'b1, 1'b1, 1'b1);
      none = '0;

      // Straight after reset memory is empty: both accesses fault, the base move is refused.
      directed_rows.push_back(access_row(vawt_pkg::OP_READ, 32'h0, 32'h0, 1, fault_rsp));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         0, none));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, vawt_pkg::CTRL_OFFSET, 32'h1,
                                         0, none));
      // Below 4 GiB: no window, plain bounds check.
      directed_rows.push_back(csr_row(vawt_pkg::CSR_GUEST_MEMORY_SIZE, 42'hFFFF_FFFF));
      directed_rows.push_back(csr_row(vawt_pkg::CSR_GUEST_ADDRESS_SHIFT, 42'h0));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, 32'h0, 32'h0, 1,
                              make_rsp(vawt_pkg::SPACE_APERTURE, 32'h0, 32'h0,
                                       1'b0, 1'b0, 1'b1)));
      directed_rows.push_back(access_row(vawt_pkg::OP_READ, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1,
                              make_rsp(vawt_pkg::SPACE_APERTURE, 32'hFFFF_FFFE, 32'h0,
                                       1'b1, 1'b0, 1'b1)));
      directed_rows.push_back(access_row(vawt_pkg::OP_READ, 32'hFFFF_FFFF, 32'h0, 1,
                                         fault_rsp));
      directed_rows.push_back(access_row(vawt_pkg::OP_READ, vawt_pkg::CTRL_OFFSET, 32'h0, 1,
                              make_rsp(vawt_pkg::SPACE_APERTURE, vawt_pkg::CTRL_OFFSET,
                                       32'h0, 1'b1, 1'b0, 1'b1)));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, vawt_pkg::CTRL_OFFSET, 32'h0,
                                         0, none));
      // A small shift pushes the top of memory past 32 bits.
      directed_rows.push_back(csr_row(vawt_pkg::CSR_GUEST_ADDRESS_SHIFT, 42'h2));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, 32'hFFFF_FFFE, 32'h1234_5678,
                                         -1, none));
      // A 1 TiB memory: window mode.
      directed_rows.push_back(csr_row(vawt_pkg::CSR_GUEST_MEMORY_SIZE, 42'h100_0000_0000));
      directed_rows.push_back(csr_row(vawt_pkg::CSR_GUEST_ADDRESS_SHIFT, 42'h0));
      directed_rows.push_back(access_row(vawt_pkg::OP_READ, WINDOW_SPAN - 1, 32'h0, 1,
                              make_rsp(vawt_pkg::SPACE_APERTURE, WINDOW_SPAN - 1, 32'h0,
                                       1'b1, 1'b0, 1'b1)));
      directed_rows.push_back(access_row(vawt_pkg::OP_READ, WINDOW_SPAN, 32'h0, 1,
                                         fault_rsp));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, WINDOW_SPAN, 32'hFFFF_FFFF,
                                         0, none));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, vawt_pkg::CTRL_OFFSET,
                                         32'h000F_FFFF, -1, none));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, 32'h000F_FFFF, 32'hA5A5_A5A5,
                                         -1, none));
      directed_rows.push_back(access_row(vawt_pkg::OP_READ, WINDOW_SPAN - 1, 32'h0,
                                         -1, none));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, vawt_pkg::CTRL_OFFSET,
                                         32'hFFFF_FFFF, -1, none));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, 32'h0, 32'h5A5A_5A5A,
                                         -1, none));
      directed_rows.push_back(csr_row(vawt_pkg::CSR_GUEST_ADDRESS_SHIFT, 42'h3FF_FFFF_FFFF));
      directed_rows.push_back(access_row(vawt_pkg::OP_READ, 32'h0, 32'h0, -1, none));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, WINDOW_SPAN - 1, 32'hFFFF_FFFF,
                                         -1, none));
      // A size past the field range lets a base beyond forty bits be accepted.
      directed_rows.push_back(csr_row(vawt_pkg::CSR_GUEST_MEMORY_SIZE, 42'h1FF_FFFF_FFFF));
      directed_rows.push_back(csr_row(vawt_pkg::CSR_GUEST_ADDRESS_SHIFT, 42'h0));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, vawt_pkg::CTRL_OFFSET,
                                         32'h001F_FFFF, -1, none));
      directed_rows.push_back(access_row(vawt_pkg::OP_READ, 32'h10, 32'h0, -1, none));
      directed_rows.push_back(access_row(vawt_pkg::OP_WRITE, 32'h0, 32'h0, -1, none));
      // Exactly 4 GiB, with the old base now out of bounds.
      directed_rows.push_back(csr_row(vawt_pkg::CSR_GUEST_MEMORY_SIZE, 42'h1_0000_0000));
      directed_rows.push_back(access_row(vawt_pkg::OP_READ, WINDOW_SPAN - 1, 32'hFFFF_FFFF,
                                         -1, none));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            write_register(row.csr_idx, row.csr_value);
         end else begin
            drive_access(row.op, row.ofs, row.data, row.typed_count, row.typed_rsp);
         end
      end

      // Random phases; every third one runs with no idling on either side.
      for (int p = 0; p < 9; p++) begin
         wide = {$urandom(), $urandom()};
         case (p)
            0: begin size_value = 42'hFFFF_FFFF; shift_value = 42'h0; end
            1: begin size_value = 42'h100_0000_0000; shift_value = wide[41:0]; end
            2: begin size_value = 42'h1_0000_0000; shift_value = {9'b0, wide[32:0]}; end
            3: begin
               size_value  = {2'b00, wide[39:32] | 8'h01, wide[31:0]};
               shift_value = 42'h3FF_FFFF_FFFF;
            end
            4: begin size_value = {11'b0, wide[30:0]}; shift_value = {10'b0, wide[63:32]}; end
            5: begin size_value = 42'h100_0000_0000; shift_value = wide[41:0]; end
            6: begin size_value = {2'b0, wide[39:0]}; shift_value = {2'b0, wide[63:24]}; end
            7: begin size_value = 42'h0; shift_value = wide[41:0]; end
            default: begin size_value = 42'h1FF_FFFF_FFFF; shift_value = 42'h0; end
         endcase
         write_register(vawt_pkg::CSR_GUEST_MEMORY_SIZE, size_value);
         write_register(vawt_pkg::CSR_GUEST_ADDRESS_SHIFT, shift_value);
         sender_max_gap     = (p % 3 == 2) ? 0 : 12;
         receiver_max_stall = (p % 3 == 2) ? 0 : 12;
         for (int k = 0; k < 95; k++) begin
            // Once mid-phase, hold the sender until everything has come out.
            if (p == 4 && k == 40) settle_block();
            draw_access(op, ofs, data);
            drive_access(op, ofs, data, -1, none);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      wait_cycles = 0;
      while (expected_accesses.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (expected_accesses.size() != 0) begin
         $error("%0d expected results never arrived", expected_accesses.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/vawt_pkg.sv
rtl/vawt_xlate.sv
rtl/vawt_rsp_stage.sv
rtl/vram_aperture_window_translator.sv
tb/testbench.sv
